// ===== hw/rtl/frb_pkg.sv =====
// ----------------------------------------------------------------------------
// frb_pkg
// Shared types, character codes and digit helpers for the radio frame builder.
// ----------------------------------------------------------------------------
package frb_pkg;

    localparam int IdBits    = 27;
    localparam int BcdBits   = 32;
    localparam int BcdSteps  = 4;
    localparam int BcdStages = 7;
    localparam int BinBits   = BcdSteps * BcdStages;
    localparam int FrameLen  = 41;
    localparam int LenBits   = 6;
    localparam int TdataBits = 80;

    localparam logic [IdBits-1:0]  IdMax      = 27'd99999999;
    localparam logic [IdBits-1:0]  OwnIdReset = 27'd40000000;
    localparam logic [LenBits-1:0] TermLen    = 6'd32;
    localparam logic [LenBits-1:0] GateLen    = 6'd41;

    localparam logic ModeTerm = 1'b0;
    localparam logic ModeGate = 1'b1;

    // sum of the fixed characters and of the '0' offsets of a terminal frame
    localparam logic [7:0] TermSumBase = 8'hC8;

    localparam logic [7:0] ChLbrace = 8'h7B;
    localparam logic [7:0] ChRbrace = 8'h7D;
    localparam logic [7:0] ChComma  = 8'h2C;
    localparam logic [7:0] ChG      = 8'h47;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChHexOfs = 8'h37;

    typedef logic [FrameLen-1:0][7:0] frame_t;

    typedef struct packed {
        logic              mode;
        logic [IdBits-1:0] tgt;
        logic [IdBits-1:0] own;
        logic [IdBits-1:0] dev;
        logic [7:0]        cnt;
        logic [7:0]        cmd;
        logic [6:0]        val;
    } item_t;

    typedef struct packed {
        logic               mode;
        logic [BinBits-1:0] tgt_bin;
        logic [BinBits-1:0] own_bin;
        logic [BinBits-1:0] dev_bin;
        logic [BcdBits-1:0] tgt_bcd;
        logic [BcdBits-1:0] own_bcd;
        logic [BcdBits-1:0] dev_bcd;
        logic [11:0]        cnt_bcd;
        logic [11:0]        cmd_bcd;
        logic [11:0]        val_bcd;
    } dd_t;

    typedef struct packed {
        logic   mode;
        frame_t bytes;
    } frm_t;

    function automatic logic [BcdBits-1:0] dd_step(input logic [BcdBits-1:0] b,
                                                   input logic bin_msb);
        logic [BcdBits-1:0] a;
        a = b;
        for (int i = 0; i < BcdBits / 4; i++) begin
            if (a[4*i +: 4] >= 4'd5) begin
                a[4*i +: 4] = a[4*i +: 4] + 4'd3;
            end
        end
        return {a[BcdBits-2:0], bin_msb};
    endfunction

    function automatic logic [11:0] bcd3(input logic [7:0] v);
        logic [11:0] a;
        a = '0;
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 3; i++) begin
                if (a[4*i +: 4] >= 4'd5) begin
                    a[4*i +: 4] = a[4*i +: 4] + 4'd3;
                end
            end
            a = {a[10:0], v[7-k]};
        end
        return a;
    endfunction

    function automatic logic [7:0] dig_char(input logic [3:0] d);
        return ChZero + {4'd0, d};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (ChZero + {4'd0, n}) : (ChHexOfs + {4'd0, n});
    endfunction

    function automatic logic [6:0] dsum8(input logic [BcdBits-1:0] b);
        logic [6:0] s;
        s = '0;
        for (int i = 0; i < BcdBits / 4; i++) begin
            s = s + {3'd0, b[4*i +: 4]};
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/frb_front.sv =====
// ----------------------------------------------------------------------------
// frb_front
// Input register: holds own id, increments the terminal counter, saturates wide fields.
// ----------------------------------------------------------------------------
module frb_front import frb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IdBits-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  item_t             in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output item_t             out_item
);

    logic              vld_reg;
    item_t             item_reg;
    item_t             item_next;
    logic [IdBits-1:0] own_id_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_item  = item_reg;

    always_comb begin
        item_next      = in_item;
        item_next.own  = (own_id_reg > IdMax) ? IdMax : own_id_reg;
        item_next.tgt  = (in_item.tgt > IdMax) ? IdMax : in_item.tgt;
        item_next.dev  = (in_item.dev > IdMax) ? IdMax : in_item.dev;
        if (in_item.mode == ModeTerm) begin
            item_next.cnt = in_item.cnt + 8'd1;
            item_next.cmd = (in_item.cmd > 8'd99) ? 8'd99 : in_item.cmd;
            item_next.val = (in_item.val > 7'd9) ? 7'd9 : in_item.val;
        end else begin
            item_next.val = (in_item.val > 7'd99) ? 7'd99 : in_item.val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= 1'b0;
            own_id_reg <= OwnIdReset;
        end else begin
            if (cfg_valid && cfg_ready) begin
                own_id_reg <= cfg_data;
            end
            if (in_ready) begin
                vld_reg <= in_valid;
            end
        end
        if (in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== hw/rtl/frb_bcd.sv =====
// ----------------------------------------------------------------------------
// frb_bcd
// Pipelined binary to decimal conversion of the three ids, four bits a stage.
// ----------------------------------------------------------------------------
module frb_bcd import frb_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output dd_t   out_dd
);

    logic [BcdStages-1:0] vld_reg;
    dd_t                  stg_reg  [BcdStages];
    dd_t                  stg_next [BcdStages];
    dd_t                  src_w    [BcdStages];
    logic                 up_vld   [BcdStages];
    logic                 rdy      [BcdStages+1];

    assign rdy[BcdStages] = out_ready;
    assign in_ready       = rdy[0];
    assign out_valid      = vld_reg[BcdStages-1];
    assign out_dd         = stg_reg[BcdStages-1];

    for (genvar s = 0; s < BcdStages; s++) begin : g_stg
        dd_t nxt;

        if (s == 0) begin : g_first
            always_comb begin
                src_w[s]         = '0;
                src_w[s].mode    = in_item.mode;
                src_w[s].tgt_bin = {{(BinBits-IdBits){1'b0}}, in_item.tgt};
                src_w[s].own_bin = {{(BinBits-IdBits){1'b0}}, in_item.own};
                src_w[s].dev_bin = {{(BinBits-IdBits){1'b0}}, in_item.dev};
                src_w[s].cnt_bcd = bcd3(in_item.cnt);
                src_w[s].cmd_bcd = bcd3(in_item.cmd);
                src_w[s].val_bcd = bcd3({1'b0, in_item.val});
            end
            assign up_vld[s] = in_valid;
        end else begin : g_rest
            assign src_w[s]  = stg_reg[s-1];
            assign up_vld[s] = vld_reg[s-1];
        end

        always_comb begin
            nxt = src_w[s];
            for (int k = 0; k < BcdSteps; k++) begin
                nxt.tgt_bcd = dd_step(nxt.tgt_bcd, nxt.tgt_bin[BinBits-1]);
                nxt.own_bcd = dd_step(nxt.own_bcd, nxt.own_bin[BinBits-1]);
                nxt.dev_bcd = dd_step(nxt.dev_bcd, nxt.dev_bin[BinBits-1]);
                nxt.tgt_bin = {nxt.tgt_bin[BinBits-2:0], 1'b0};
                nxt.own_bin = {nxt.own_bin[BinBits-2:0], 1'b0};
                nxt.dev_bin = {nxt.dev_bin[BinBits-2:0], 1'b0};
            end
        end

        assign stg_next[s] = nxt;
        assign rdy[s]      = !vld_reg[s] || rdy[s+1];
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < BcdStages; s++) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (rdy[s]) begin
                vld_reg[s] <= up_vld[s];
            end
            if (rdy[s]) begin
                stg_reg[s] <= stg_next[s];
            end
        end
    end

endmodule

// ===== hw/rtl/frb_fmt.sv =====
// ----------------------------------------------------------------------------
// frb_fmt
// Frame assembly in two stages: lay out the characters, then add the terminal checksum.
// ----------------------------------------------------------------------------
module frb_fmt import frb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  dd_t  in_dd,
    output logic out_valid,
    input  logic out_ready,
    output frm_t out_frm
);

    logic       v1_reg;
    logic       v2_reg;
    logic       rdy1;
    logic       rdy2;
    logic       mode_reg;
    frame_t     bytes_reg;
    frame_t     bytes_next;
    logic [6:0] tsum_reg;
    logic [6:0] osum_reg;
    logic [5:0] ssum_reg;
    logic [5:0] ssum_next;
    frm_t       frm_reg;
    frm_t       frm_next;
    logic [7:0] sum8;

    assign rdy2      = !v2_reg || out_ready;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v2_reg;
    assign out_frm   = frm_reg;

    assign ssum_next = {2'd0, in_dd.cnt_bcd[11:8]} + {2'd0, in_dd.cnt_bcd[7:4]}
                     + {2'd0, in_dd.cnt_bcd[3:0]} + {2'd0, in_dd.cmd_bcd[7:4]}
                     + {2'd0, in_dd.cmd_bcd[3:0]} + {2'd0, in_dd.val_bcd[3:0]};

    always_comb begin
        bytes_next = '0;
        if (in_dd.mode == ModeTerm) begin
            bytes_next[0] = ChLbrace;
            for (int i = 0; i < 8; i++) begin
                bytes_next[1+i]  = dig_char(in_dd.tgt_bcd[4*(7-i) +: 4]);
                bytes_next[10+i] = dig_char(in_dd.own_bcd[4*(7-i) +: 4]);
            end
            bytes_next[9]  = ChComma;
            bytes_next[18] = ChComma;
            for (int i = 0; i < 3; i++) begin
                bytes_next[19+i] = dig_char(in_dd.cnt_bcd[4*(2-i) +: 4]);
            end
            bytes_next[22] = ChComma;
            bytes_next[23] = dig_char(in_dd.cmd_bcd[7:4]);
            bytes_next[24] = dig_char(in_dd.cmd_bcd[3:0]);
            bytes_next[25] = ChComma;
            bytes_next[26] = dig_char(in_dd.val_bcd[3:0]);
            bytes_next[27] = ChRbrace;
        end else begin
            bytes_next[0] = ChG;
            bytes_next[1] = ChLbrace;
            for (int i = 0; i < 8; i++) begin
                bytes_next[2+i]  = dig_char(in_dd.tgt_bcd[4*(7-i) +: 4]);
                bytes_next[11+i] = dig_char(in_dd.own_bcd[4*(7-i) +: 4]);
                bytes_next[20+i] = dig_char(in_dd.dev_bcd[4*(7-i) +: 4]);
            end
            bytes_next[10] = ChComma;
            bytes_next[19] = ChComma;
            bytes_next[28] = ChComma;
            for (int i = 0; i < 3; i++) begin
                bytes_next[29+i] = dig_char(in_dd.cnt_bcd[4*(2-i) +: 4]);
                bytes_next[33+i] = dig_char(in_dd.cmd_bcd[4*(2-i) +: 4]);
            end
            bytes_next[32] = ChComma;
            bytes_next[36] = ChComma;
            bytes_next[37] = dig_char(in_dd.val_bcd[7:4]);
            bytes_next[38] = dig_char(in_dd.val_bcd[3:0]);
            bytes_next[39] = ChRbrace;
            bytes_next[40] = ChG;
        end
    end

    assign sum8 = TermSumBase + {1'b0, tsum_reg} + {1'b0, osum_reg} + {2'd0, ssum_reg};

    always_comb begin
        frm_next.mode  = mode_reg;
        frm_next.bytes = bytes_reg;
        if (mode_reg == ModeTerm) begin
            frm_next.bytes[28] = hex_char(sum8[7:4]);
            frm_next.bytes[29] = hex_char(sum8[3:0]);
            frm_next.bytes[30] = ChCr;
            frm_next.bytes[31] = ChLf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
        if (rdy1) begin
            mode_reg  <= in_dd.mode;
            bytes_reg <= bytes_next;
            tsum_reg  <= dsum8(in_dd.tgt_bcd);
            osum_reg  <= dsum8(in_dd.own_bcd);
            ssum_reg  <= ssum_next;
        end
        if (rdy2) begin
            frm_reg <= frm_next;
        end
    end

endmodule

// ===== hw/rtl/frb_ser.sv =====
// ----------------------------------------------------------------------------
// frb_ser
// Output serializer: shifts a finished frame out one byte per word.
// ----------------------------------------------------------------------------
module frb_ser import frb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  frm_t       in_frm,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    frame_t             sh_reg;
    logic [LenBits-1:0] rem_reg;
    logic               busy;
    logic               last_out;

    assign busy     = (rem_reg != '0);
    assign last_out = (rem_reg == LenBits'(1));
    assign in_ready = !busy || (m_tready && last_out);
    assign m_tvalid = busy;
    assign m_tdata  = sh_reg[0];
    assign m_tlast  = last_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (in_ready && in_valid) begin
            rem_reg <= (in_frm.mode == ModeTerm) ? TermLen : GateLen;
        end else if (busy && m_tready) begin
            rem_reg <= rem_reg - LenBits'(1);
        end
        if (in_ready && in_valid) begin
            sh_reg <= in_frm.bytes;
        end else if (busy && m_tready) begin
            sh_reg <= {8'd0, sh_reg[FrameLen-1:1]};
        end
    end

endmodule

// ===== hw/rtl/ascii_radio_frame_builder.sv =====
// The output serializer, moving one byte per word, sets the frame rate: a terminal
// frame is 32 bytes and a gateway frame 41; the front pipeline takes a word every
// cycle until it backs up behind the serializer.
// Reset: synchronous, active low; clears all valid bits and the byte count and
// loads own_id with 40000000.
// ----------------------------------------------------------------------------
// ascii_radio_frame_builder
// Builds terminal and gateway ASCII radio frames and streams them as bytes.
// ----------------------------------------------------------------------------
module ascii_radio_frame_builder import frb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [IdBits-1:0]    cfg_data,   // own_id
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // dest_addr[26:0], dev_addr[53:27], count_or_rssi[61:54], command[69:62],
    // value[76:70], zero[79:77]
    input  logic [TdataBits-1:0] s_tdata,
    input  logic                 s_tuser,    // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,    // frame_byte
    output logic                 m_tlast     // last
);

    item_t raw_item;
    item_t fe_item;
    logic  fe_valid;
    logic  fe_ready;
    dd_t   dd;
    logic  dd_valid;
    logic  dd_ready;
    frm_t  frm;
    logic  frm_valid;
    logic  frm_ready;

    always_comb begin
        raw_item.mode = s_tuser;
        raw_item.tgt  = s_tdata[26:0];
        raw_item.own  = '0;
        raw_item.dev  = s_tdata[53:27];
        raw_item.cnt  = s_tdata[61:54];
        raw_item.cmd  = s_tdata[69:62];
        raw_item.val  = s_tdata[76:70];
    end

    frb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (raw_item),
        .out_valid (fe_valid),
        .out_ready (fe_ready),
        .out_item  (fe_item)
    );

    frb_bcd u_bcd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_item   (fe_item),
        .out_valid (dd_valid),
        .out_ready (dd_ready),
        .out_dd    (dd)
    );

    frb_fmt u_fmt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dd_valid),
        .in_ready  (dd_ready),
        .in_dd     (dd),
        .out_valid (frm_valid),
        .out_ready (frm_ready),
        .out_frm   (frm)
    );

    frb_ser u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (frm_valid),
        .in_ready (frm_ready),
        .in_frm   (frm),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb - ascii_radio_frame_builder regression
// Sends terminal and gateway messages, rebuilds every frame byte in the bench
// and compares the streamed bytes and the frame end flag word by word, under
// random bursts on the input, random and long stalls on the output, and a
// sweep of own_id values.
// ----------------------------------------------------------------------------
module tb;
    import frb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [IdBits-1:0] IdAllOnes = {IdBits{1'b1}};

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } frame_word_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [IdBits-1:0]    cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TdataBits-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic                 m_tlast;

    frame_word_t       frame_words_q[$];
    logic [7:0]        frame_chars[$];
    logic [IdBits-1:0] node_id;
    int                err_count;
    int                burst_left;
    int                gap_max;
    int                stall_pct;
    int                hold_cycles;

    ascii_radio_frame_builder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < 40) begin
            $display("%0t ns: mismatch %s: got %0h expected %0h", $time, what, got, want);
        end
        err_count++;
    endtask

    // ---- frame prediction ----
    task automatic append_dec(input int unsigned v, input int n);
        int unsigned lim;
        int unsigned scale;
        lim = 1;
        for (int i = 0; i < n; i++) lim = lim * 10;
        if (v > lim - 1) v = lim - 1;
        scale = lim / 10;
        for (int i = 0; i < n; i++) begin
            frame_chars.push_back(ChZero + 8'((v / scale) % 10));
            scale = scale / 10;
        end
    endtask

    function automatic logic [7:0] hex_of(input logic [3:0] nib);
        return (nib < 4'd10) ? ChZero + {4'd0, nib} : ChHexOfs + {4'd0, nib};
    endfunction

    task automatic build_expected_frame(input logic mode, input logic [IdBits-1:0] tgt,
                                        input logic [IdBits-1:0] dev, input logic [7:0] cnt,
                                        input logic [7:0] cmd, input logic [6:0] val);
        logic [7:0]  sum;
        frame_word_t w;
        frame_chars.delete();
        if (mode == ModeTerm) begin
            frame_chars.push_back(ChLbrace);
            append_dec(32'(tgt), 8);
            frame_chars.push_back(ChComma);
            append_dec(32'(node_id), 8);
            frame_chars.push_back(ChComma);
            append_dec(32'(8'(cnt + 8'd1)), 3);
            frame_chars.push_back(ChComma);
            append_dec(32'(cmd), 2);
            frame_chars.push_back(ChComma);
            append_dec(32'(val), 1);
            frame_chars.push_back(ChRbrace);
            sum = '0;
            foreach (frame_chars[i]) sum = sum + frame_chars[i];
            frame_chars.push_back(hex_of(sum[7:4]));
            frame_chars.push_back(hex_of(sum[3:0]));
            frame_chars.push_back(ChCr);
            frame_chars.push_back(ChLf);
        end else begin
            frame_chars.push_back(ChG);
            frame_chars.push_back(ChLbrace);
            append_dec(32'(tgt), 8);
            frame_chars.push_back(ChComma);
            append_dec(32'(node_id), 8);
            frame_chars.push_back(ChComma);
            append_dec(32'(dev), 8);
            frame_chars.push_back(ChComma);
            append_dec(32'(cnt), 3);
            frame_chars.push_back(ChComma);
            append_dec(32'(cmd), 3);
            frame_chars.push_back(ChComma);
            append_dec(32'(val), 2);
            frame_chars.push_back(ChRbrace);
            frame_chars.push_back(ChG);
        end
        foreach (frame_chars[i]) begin
            w.ch   = frame_chars[i];
            w.last = (i == frame_chars.size() - 1);
            frame_words_q.push_back(w);
        end
    endtask

    // ---- input side ----
    task automatic send_msg(input logic mode, input logic [IdBits-1:0] tgt,
                            input logic [IdBits-1:0] dev, input logic [7:0] cnt,
                            input logic [7:0] cmd, input logic [6:0] val);
        int gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {3'b000, val, cmd, cnt, dev, tgt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        build_expected_frame(mode, tgt, dev, cnt, cmd, val);
        if (gap_max > 0) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, gap_max);
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
                burst_left = $urandom_range(1, 8);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic drain_frames();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (frame_words_q.size() > 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_own_id(input logic [IdBits-1:0] v);
        drain_frames();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        node_id = v;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [IdBits-1:0] rand_id();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return IdMax;
            2:       return IdAllOnes;
            3, 4:    return IdBits'($urandom);
            default: return IdBits'($urandom_range(0, 99999999));
        endcase
    endfunction

    task automatic send_random_msg();
        logic       mode;
        logic [7:0] cmd;
        logic [6:0] val;
        mode = ($urandom_range(0, 1) == 0) ? ModeTerm : ModeGate;
        if ($urandom_range(0, 3) == 0) begin
            cmd = 8'($urandom);
            val = 7'($urandom);
        end else if (mode == ModeTerm) begin
            cmd = 8'($urandom_range(0, 99));
            val = 7'($urandom_range(0, 9));
        end else begin
            cmd = 8'($urandom);
            val = 7'($urandom_range(0, 99));
        end
        send_msg(mode, rand_id(), rand_id(), 8'($urandom), cmd, val);
    endtask

    // ---- output side ----
    initial begin
        int phase_cnt;
        phase_cnt = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            phase_cnt++;
            if (phase_cnt % 256 == 0) begin
                case ($urandom_range(0, 3))
                    0, 1: stall_pct = 0;
                    2:    stall_pct = 25;
                    default: stall_pct = 65;
                endcase
            end
            if (hold_cycles > 0) begin
                m_tready = 1'b0;
                hold_cycles--;
            end else begin
                m_tready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        frame_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_words_q.size() == 0) begin
                report_mismatch("unexpected word", int'(m_tdata), 0);
            end else begin
                w = frame_words_q.pop_front();
                if (m_tdata !== w.ch) begin
                    report_mismatch("frame byte", int'(m_tdata), int'(w.ch));
                end
                if (m_tlast !== w.last) begin
                    report_mismatch("tlast", int'(m_tlast), int'(w.last));
                end
            end
        end
    end

    // ---- tests ----
    task automatic test_reset_id();
        send_msg(ModeTerm, 27'd12345678, 27'd0, 8'd0, 8'd1, 7'd5);
        send_msg(ModeGate, 27'd12345678, 27'd87654321, 8'd77, 8'd123, 7'd42);
    endtask

    task automatic test_field_extremes();
        send_msg(ModeTerm, '0, '0, 8'd0, 8'd0, 7'd0);
        send_msg(ModeTerm, IdMax, IdAllOnes, 8'd254, 8'd99, 7'd9);
        send_msg(ModeTerm, IdMax + 27'd1, '0, 8'd255, 8'd100, 7'd10);
        send_msg(ModeTerm, IdAllOnes, 27'h5555555, 8'd98, 8'd255, 7'd127);
        send_msg(ModeTerm, 27'd99999998, 27'h2AAAAAA, 8'd8, 8'd42, 7'd100);
        send_msg(ModeGate, '0, '0, 8'd0, 8'd0, 7'd0);
        send_msg(ModeGate, IdMax, IdMax, 8'd255, 8'd255, 7'd99);
        send_msg(ModeGate, IdMax + 27'd1, IdMax + 27'd1, 8'd128, 8'd99, 7'd100);
        send_msg(ModeGate, IdAllOnes, IdAllOnes, 8'd1, 8'd100, 7'd127);
        send_msg(ModeGate, 27'h2AAAAAA, 27'h5555555, 8'd170, 8'd85, 7'h55);
        send_msg(ModeGate, 27'h5555555, 27'h2AAAAAA, 8'd85, 8'd170, 7'h2A);
        send_msg(ModeTerm, 27'd10000000, 27'd1, 8'd9, 8'd10, 7'd1);
    endtask

    task automatic test_own_id_sweep();
        logic [IdBits-1:0] ids[6];
        ids = '{'0, IdMax, IdMax + 27'd1, IdAllOnes, IdBits'($urandom), OwnIdReset};
        foreach (ids[i]) begin
            write_own_id(ids[i]);
            repeat (3) send_random_msg();
            send_msg(ModeTerm, 27'd31415926, '0, 8'd255, 8'd7, 7'd3);
        end
    endtask

    task automatic test_output_backpressure();
        drain_frames();
        gap_max     = 0;
        hold_cycles = 700;
        repeat (20) send_random_msg();
        drain_frames();
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < 210; n++) begin
            if (n % 35 == 0) begin
                case ($urandom_range(0, 3))
                    0, 1: gap_max = 0;
                    2:    gap_max = 4;
                    default: gap_max = 40;
                endcase
                burst_left = $urandom_range(1, 8);
            end
            if (n == 105) write_own_id(IdBits'($urandom_range(0, 99999999)));
            send_random_msg();
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ModeTerm;
        node_id     = OwnIdReset;
        err_count   = 0;
        burst_left  = 3;
        gap_max     = 3;
        stall_pct   = 20;
        hold_cycles = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_id();
        test_field_extremes();
        test_own_id_sweep();
        test_output_backpressure();
        test_random_traffic();

        drain_frames();
        repeat (20) @(posedge aclk);
        if (frame_words_q.size() != 0) report_mismatch("words left over", frame_words_q.size(), 0);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
